>>> rtl/mcepwm_pkg.sv
// ----------------------------------------------------------------------------
// mcepwm_pkg: shared constants and types of the edge-compare PWM core
// Channel count, field widths, function and register codes, and the
// control structs passed between the core and the channel bank.
// ----------------------------------------------------------------------------
package mcepwm_pkg;

	// channel count (1..16) and field widths
	localparam int CHANNELS   = 16;
	localparam int EDGE_W     = 8;
	localparam int CNT_W      = 8;
	localparam int MASK_W     = 16;
	localparam int CH_SEL_W   = 4;
	localparam int FUNC_W     = 3;
	localparam int REG_ADDR_W = 4;
	localparam int REG_IDX_W  = 2;
	localparam int APB_DATA_W = 32;

	// function codes of an input word
	localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_WR_RISE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_WR_FALL = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_SYNC    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_PRESCALE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SHADOW   = 2'd3;

	// per-word control from the core to the channel bank
	typedef struct packed {
		logic                step_adv;
		logic [CNT_W-1:0]    step;
		logic                copy;
		logic                wr_rise;
		logic                wr_fall;
		logic [CH_SEL_W-1:0] wr_chan;
		logic [EDGE_W-1:0]   wr_value;
		logic [CH_SEL_W-1:0] rd_chan;
	} bank_ctrl_t;

	// configuration seen by the channel bank
	typedef struct packed {
		logic [CNT_W-1:0]  last_step;
		logic [MASK_W-1:0] enable;
		logic [MASK_W-1:0] shadow_mask;
		logic              en_we;
		logic [MASK_W-1:0] en_value;
	} bank_cfg_t;

endpackage

>>> rtl/mcepwm_if.sv
// ----------------------------------------------------------------------------
// mcepwm_if: valid/ready channels of the edge-compare PWM core
// Command channel (function, channel, edge value) and result channel
// (output levels, period start flag, edge read-back).
// ----------------------------------------------------------------------------
interface mcepwm_in_if
	import mcepwm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [CH_SEL_W-1:0] channel;
	logic [EDGE_W-1:0]   edge_value;

	modport source (output valid, output func, output channel, output edge_value,
		input ready);
	modport sink (input valid, input func, input channel, input edge_value,
		output ready);
endinterface

interface mcepwm_out_if
	import mcepwm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pwm_out;
	logic              period_start;
	logic [EDGE_W-1:0] read_rising;
	logic [EDGE_W-1:0] read_falling;

	modport source (output valid, output pwm_out, output period_start,
		output read_rising, output read_falling, input ready);
	modport sink (input valid, input pwm_out, input period_start,
		input read_rising, input read_falling, output ready);
endinterface

>>> rtl/mcepwm_chan_bank.sv
// ----------------------------------------------------------------------------
// mcepwm_chan_bank: per-channel edge registers and compare logic
// Holds active and shadow edges and the output level of every channel,
// applies edge writes, the shadow copy and the step compares.
// ----------------------------------------------------------------------------
module mcepwm_chan_bank
	import mcepwm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  bank_ctrl_t            ctrl,
	input  bank_cfg_t             cfg,
	output logic [CHANNELS-1:0]   level_next,
	output logic [EDGE_W-1:0]     rd_rise,
	output logic [EDGE_W-1:0]     rd_fall
);

	logic [EDGE_W-1:0]   act_rise_q  [CHANNELS];
	logic [EDGE_W-1:0]   act_fall_q  [CHANNELS];
	logic [EDGE_W-1:0]   shd_rise_q  [CHANNELS];
	logic [EDGE_W-1:0]   shd_fall_q  [CHANNELS];
	logic [EDGE_W-1:0]   eff_rise    [CHANNELS];
	logic [EDGE_W-1:0]   eff_fall    [CHANNELS];
	logic [CHANNELS-1:0] level_q;
	logic [CHANNELS-1:0] level_d;
	logic [CHANNELS-1:0] wr_hit;
	logic [CHANNELS-1:0] rd_hit;
	logic [CHANNELS-1:0] copy_ch;
	logic [CHANNELS-1:0] rise_hit;
	logic [CHANNELS-1:0] fall_hit;

	// channel decode and edges in effect after an optional shadow copy
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			wr_hit[i]   = (ctrl.wr_chan == CH_SEL_W'(i));
			rd_hit[i]   = (ctrl.rd_chan == CH_SEL_W'(i));
			copy_ch[i]  = ctrl.copy && cfg.shadow_mask[i];
			eff_rise[i] = copy_ch[i] ? shd_rise_q[i] : act_rise_q[i];
			eff_fall[i] = copy_ch[i] ? shd_fall_q[i] : act_fall_q[i];
			// an edge beyond the period never fires
			rise_hit[i] = (eff_rise[i] == ctrl.step) && (eff_rise[i] <= cfg.last_step);
			fall_hit[i] = (eff_fall[i] == ctrl.step) && (eff_fall[i] <= cfg.last_step);
		end
	end

	// output level after this word
	always_comb begin
		level_next = level_q;
		for (int i = 0; i < CHANNELS; i++) begin
			if (ctrl.step_adv) begin
				if (!cfg.enable[i]) begin
					level_next[i] = 1'b0;
				end else if (rise_hit[i] && fall_hit[i]) begin
					level_next[i] = ~level_q[i];
				end else if (rise_hit[i]) begin
					level_next[i] = 1'b1;
				end else if (fall_hit[i]) begin
					level_next[i] = 1'b0;
				end
			end
		end
		// a new enable mask drops disabled channels low
		level_d = cfg.en_we ? (level_q & cfg.en_value[CHANNELS-1:0]) : level_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else begin
			level_q <= level_d;
		end
	end

	// edge registers: direct writes, shadow writes and period-start copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				act_rise_q[i] <= '0;
				act_fall_q[i] <= '0;
				shd_rise_q[i] <= '0;
				shd_fall_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (copy_ch[i]) begin
					act_rise_q[i] <= shd_rise_q[i];
					act_fall_q[i] <= shd_fall_q[i];
				end
				if (ctrl.wr_rise && wr_hit[i]) begin
					if (cfg.shadow_mask[i]) begin
						shd_rise_q[i] <= ctrl.wr_value;
					end else begin
						act_rise_q[i] <= ctrl.wr_value;
					end
				end
				if (ctrl.wr_fall && wr_hit[i]) begin
					if (cfg.shadow_mask[i]) begin
						shd_fall_q[i] <= ctrl.wr_value;
					end else begin
						act_fall_q[i] <= ctrl.wr_value;
					end
				end
			end
		end
	end

	// read-back mux, zero for a channel that does not exist
	always_comb begin
		rd_rise = '0;
		rd_fall = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (rd_hit[i]) begin
				rd_rise = act_rise_q[i];
				rd_fall = act_fall_q[i];
			end
		end
	end

endmodule

>>> rtl/multichannel_edge_pwm_core.sv
// ----------------------------------------------------------------------------
// multichannel_edge_pwm_core: 16-channel edge-compare PWM generator
//
// Command words arrive on item_in: a tick advances the prescale and step
// counters, other functions write a rising or falling edge, request a
// shadow sync, or read back a channel's active edges. Every command word
// produces exactly one result word on item_out carrying the channel output
// levels after that word, a period start flag and the read-back edges.
// Registers (prescale, last step of the period, channel enable mask,
// shadow mask) are written over the APB port at byte addresses 0, 4, 8
// and 12; the user writes them only while idle, the core does not enforce it.
//
// A word passes an input register, then the compare and update logic
// feeding the result register. Throughput is one word per cycle while
// the receiver takes results; the single result register is reloaded in
// the same cycle it is taken. When the receiver stalls, the result holds,
// one more word is parked in the input register, then item_in.ready drops.
// Reset clears counters, edges, levels, registers and both pipeline valids;
// the first word can be sent in the cycle after reset is released.
// ----------------------------------------------------------------------------
module multichannel_edge_pwm_core
	import mcepwm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	mcepwm_in_if.sink             item_in,
	mcepwm_out_if.source          item_out
);

	// configuration registers
	logic [CNT_W-1:0]     prescale_q;
	logic [CNT_W-1:0]     period_q;
	logic [MASK_W-1:0]    enable_q;
	logic [MASK_W-1:0]    shadow_q;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;

	// stage 1: input register
	logic                 v_s1;
	logic [FUNC_W-1:0]    func_s1;
	logic [CH_SEL_W-1:0]  chan_s1;
	logic [EDGE_W-1:0]    val_s1;

	// stage 2: result register
	logic                 v_s2;
	logic [MASK_W-1:0]    pwm_s2;
	logic                 start_s2;
	logic [EDGE_W-1:0]    rd_rise_s2;
	logic [EDGE_W-1:0]    rd_fall_s2;

	// counters and sync request
	logic [CNT_W-1:0]     pcnt_q;
	logic [CNT_W-1:0]     step_q;
	logic                 sync_pend_q;

	logic                 adv;
	logic                 take_in;
	logic                 fire;
	logic                 is_tick;
	logic                 pre_wrap;
	logic                 per_wrap;
	logic                 step_adv;
	logic                 start;
	logic [CNT_W-1:0]     step_next;
	bank_ctrl_t           bctrl;
	bank_cfg_t            bcfg;
	logic [CHANNELS-1:0]  level_next;
	logic [EDGE_W-1:0]    rd_rise;
	logic [EDGE_W-1:0]    rd_fall;

	// APB register port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[REG_ADDR_W-1:REG_ADDR_W-REG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			period_q   <= '0;
			enable_q   <= '0;
			shadow_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PRESCALE: prescale_q <= pwdata[CNT_W-1:0];
				REG_PERIOD:   period_q   <= pwdata[CNT_W-1:0];
				REG_ENABLE:   enable_q   <= pwdata[MASK_W-1:0];
				REG_SHADOW:   shadow_q   <= pwdata[MASK_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PRESCALE: prdata = APB_DATA_W'(prescale_q);
			REG_PERIOD:   prdata = APB_DATA_W'(period_q);
			REG_ENABLE:   prdata = APB_DATA_W'(enable_q);
			REG_SHADOW:   prdata = APB_DATA_W'(shadow_q);
			default:      prdata = '0;
		endcase
	end

	// pipeline handshake
	assign adv          = !v_s2 || item_out.ready;
	assign item_in.ready = !v_s1 || adv;
	assign take_in      = item_in.valid && item_in.ready;
	assign fire         = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take_in || (v_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1 <= item_in.func;
			chan_s1 <= item_in.channel;
			val_s1  <= item_in.edge_value;
		end
	end

	// prescale and step counters
	assign is_tick   = fire && (func_s1 == FUNC_TICK);
	assign pre_wrap  = (pcnt_q >= prescale_q);
	assign per_wrap  = (step_q >= period_q);
	assign step_adv  = is_tick && pre_wrap;
	assign start     = step_adv && per_wrap;
	assign step_next = per_wrap ? '0 : step_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			step_q      <= '0;
			sync_pend_q <= 1'b0;
		end else begin
			if (is_tick) begin
				pcnt_q <= pre_wrap ? '0 : pcnt_q + CNT_W'(1);
			end
			if (step_adv) begin
				step_q <= step_next;
			end
			if (start) begin
				sync_pend_q <= 1'b0;
			end else if (fire && (func_s1 == FUNC_SYNC)) begin
				sync_pend_q <= 1'b1;
			end
		end
	end

	// channel bank control
	always_comb begin
		bctrl.step_adv = step_adv;
		bctrl.step     = step_next;
		bctrl.copy     = start && sync_pend_q;
		bctrl.wr_rise  = fire && (func_s1 == FUNC_WR_RISE);
		bctrl.wr_fall  = fire && (func_s1 == FUNC_WR_FALL);
		bctrl.wr_chan  = chan_s1;
		bctrl.wr_value = val_s1;
		bctrl.rd_chan  = chan_s1;

		bcfg.last_step    = period_q;
		bcfg.enable       = enable_q;
		bcfg.shadow_mask  = shadow_q;
		bcfg.en_we        = cfg_we && (cfg_idx == REG_ENABLE);
		bcfg.en_value     = pwdata[MASK_W-1:0];
	end

	mcepwm_chan_bank u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (bctrl),
		.cfg        (bcfg),
		.level_next (level_next),
		.rd_rise    (rd_rise),
		.rd_fall    (rd_fall)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= fire || (v_s2 && !item_out.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pwm_s2     <= MASK_W'(level_next & enable_q[CHANNELS-1:0]);
			start_s2   <= start;
			rd_rise_s2 <= (func_s1 == FUNC_READ) ? rd_rise : '0;
			rd_fall_s2 <= (func_s1 == FUNC_READ) ? rd_fall : '0;
		end
	end

	assign item_out.valid        = v_s2;
	assign item_out.pwm_out      = pwm_s2;
	assign item_out.period_start = start_s2;
	assign item_out.read_rising  = rd_rise_s2;
	assign item_out.read_falling = rd_fall_s2;

endmodule

>>> rtl/mcepwm_checker.sv
// ----------------------------------------------------------------------------
// mcepwm_checker: port-level assertions for the edge-compare PWM core
// Checks backpressure, latency and result stability seen at the ports.
// ----------------------------------------------------------------------------
module mcepwm_checker
	import mcepwm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [MASK_W-1:0] pwm_out,
	input logic              period_start,
	input logic [EDGE_W-1:0] read_rising,
	input logic [EDGE_W-1:0] read_falling
);

	// input side only backs up when the result word is stalled
	a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input not ready while result side is free");

	// an accepted word reaches the result register once the output is free
	a_two_cycle_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
		else $error("accepted word did not produce a result");

	// a stalled result word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pwm_out)
			&& $stable(period_start) && $stable(read_rising) && $stable(read_falling)))
		else $error("stalled result word changed");

	// an empty pipeline accepts input right away
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty result register");

endmodule

bind multichannel_edge_pwm_core mcepwm_checker u_mcepwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item_in.valid),
	.in_ready     (item_in.ready),
	.out_valid    (item_out.valid),
	.out_ready    (item_out.ready),
	.pwm_out      (item_out.pwm_out),
	.period_start (item_out.period_start),
	.read_rising  (item_out.read_rising),
	.read_falling (item_out.read_falling)
);
